/* hdl/rvie_pkg.sv */
package rvie_pkg;

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6f;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ERR    = 2'd1,
        ST_LOOP   = 2'd2,
        ST_HALTED = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic        ld;
        logic [31:0] val;
        logic        st;
        logic        err;
        logic [31:0] ea;
    } t_exec;

endpackage

/* hdl/rv32i_integer_execute.sv */
// RV32I integer execute unit. One instruction word enters per cycle, while
// o_stall is low, at the pc that this block keeps (reset to zero). The
// register file is read at the edge that takes the word into the execute
// register, which then executes it with the data memory access, the result
// being held in the output register until taken. Sustained throughput is
// one instruction per cycle while the output is not stalled; back-to-back
// dependencies are forwarded, and a load result feeds the next instruction
// straight from the data memory read port. After reset the data memory is
// cleared one word per cycle, and no instruction is taken until that ends.
// An unknown opcode or function code, or an instruction that jumps to itself,
// halts the block until reset; later instructions then report the halted
// status with no effect.
module rv32i_integer_execute import rvie_pkg::*; #(
    parameter int DATA_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_rd_write,
    output logic [4:0]  o_rd_index,
    output logic [31:0] o_rd_value,
    output logic        o_store_valid,
    output logic [9:0]  o_store_addr,
    output logic [31:0] o_store_data,
    output logic [1:0]  o_status
);

    localparam int AW = $clog2(DATA_WORDS);

    logic          r_clearing;
    logic [AW-1:0] r_clr_cnt;
    logic [31:0]   r_pc;
    logic          r_halted;
    logic [31:0]   r_reg_vld;

    logic          r_s1_v;
    logic [31:0]   r_s1_instr;

    logic          r_s2_v;
    logic [31:0]   r_s2_npc;
    logic          r_s2_wr;
    logic [4:0]    r_s2_rd;
    logic          r_s2_ld;
    logic [31:0]   r_s2_val;
    logic          r_s2_st;
    logic [AW-1:0] r_s2_saddr;
    logic [31:0]   r_s2_sdata;
    t_status       r_s2_status;

    logic          r_w_v;
    logic [4:0]    r_w_rd;
    logic [31:0]   r_w_val;

    logic          acc_in;
    logic          acc_out;
    logic          s2_free;
    logic          s1_adv;
    logic [4:0]    rs1_raddr;
    logic [4:0]    rs2_raddr;
    logic [31:0]   rs1_ram;
    logic [31:0]   rs2_ram;
    logic [31:0]   rs1_val;
    logic [31:0]   rs2_val;
    logic [31:0]   s2_rd_value;
    logic [31:0]   mem_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] maddr;
    t_exec         ex;
    logic          eff;
    t_status       n_status;

    assign s2_free = !r_s2_v || !i_stall;
    assign s1_adv  = r_s1_v && s2_free;
    assign o_stall = r_clearing || (r_s1_v && !s1_adv);
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = r_s2_v && !i_stall;

    assign rs1_raddr = acc_in ? i_instr_word[19:15] : r_s1_instr[19:15];
    assign rs2_raddr = acc_in ? i_instr_word[24:20] : r_s1_instr[24:20];

    assign s2_rd_value = r_s2_ld ? mem_rdata : r_s2_val;

    rvie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (acc_out && r_s2_wr),
        .i_waddr (r_s2_rd),
        .i_wdata (s2_rd_value),
        .i_re    (1'b1),
        .i_raddr (rs1_raddr),
        .o_rdata (rs1_ram)
    );

    rvie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (acc_out && r_s2_wr),
        .i_waddr (r_s2_rd),
        .i_wdata (s2_rd_value),
        .i_re    (1'b1),
        .i_raddr (rs2_raddr),
        .o_rdata (rs2_ram)
    );

    // The pending write in the output stage is newest, then the write that
    // landed at the same edge as the read; unwritten registers read as zero.
    always_comb begin
        if (r_s2_v && r_s2_wr && (r_s2_rd == r_s1_instr[19:15])) begin
            rs1_val = s2_rd_value;
        end else if (r_w_v && (r_w_rd == r_s1_instr[19:15])) begin
            rs1_val = r_w_val;
        end else if (r_reg_vld[r_s1_instr[19:15]]) begin
            rs1_val = rs1_ram;
        end else begin
            rs1_val = '0;
        end
        if (r_s2_v && r_s2_wr && (r_s2_rd == r_s1_instr[24:20])) begin
            rs2_val = s2_rd_value;
        end else if (r_w_v && (r_w_rd == r_s1_instr[24:20])) begin
            rs2_val = r_w_val;
        end else if (r_reg_vld[r_s1_instr[24:20]]) begin
            rs2_val = rs2_ram;
        end else begin
            rs2_val = '0;
        end
    end

    rvie_exec u_exec (
        .i_instr   (r_s1_instr),
        .i_pc      (r_pc),
        .i_rs1_val (rs1_val),
        .i_rs2_val (rs2_val),
        .o_res     (ex)
    );

    generate
        if ((DATA_WORDS & (DATA_WORDS - 1)) == 0) begin : g_mask
            assign maddr = ex.ea[AW-1:0];
        end else begin : g_recip
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DATA_WORDS);
            logic [63:0] prod;
            logic [31:0] quo;
            logic [31:0] rem;
            logic [31:0] rem_fix;
            assign prod    = 64'(ex.ea) * 64'(RECIP);
            assign quo     = prod[63:32];
            assign rem     = ex.ea - 32'(quo * 32'(DATA_WORDS));
            assign rem_fix = (rem >= 32'(DATA_WORDS)) ? rem - 32'(DATA_WORDS) : rem;
            assign maddr   = rem_fix[AW-1:0];
        end
    endgenerate

    assign eff = !r_halted && !ex.err;

    always_comb begin
        if (r_halted) begin
            n_status = ST_HALTED;
        end else if (ex.err) begin
            n_status = ST_ERR;
        end else if (ex.npc == r_pc) begin
            n_status = ST_LOOP;
        end else begin
            n_status = ST_OK;
        end
    end

    assign mem_we    = r_clearing || (s1_adv && eff && ex.st);
    assign mem_waddr = r_clearing ? r_clr_cnt : maddr;
    assign mem_wdata = r_clearing ? 32'd0 : rs2_val;

    rvie_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (s1_adv),
        .i_raddr (maddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
            r_pc       <= '0;
            r_halted   <= 1'b0;
            r_reg_vld  <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_w_v      <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(DATA_WORDS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (acc_in) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end

            if (s1_adv) begin
                r_s2_v <= 1'b1;
                if (eff) begin
                    r_pc <= ex.npc;
                end
                if (!r_halted && (n_status != ST_OK)) begin
                    r_halted <= 1'b1;
                end
            end else if (acc_out) begin
                r_s2_v <= 1'b0;
            end

            r_w_v <= acc_out && r_s2_wr;
            if (acc_out && r_s2_wr) begin
                r_reg_vld[r_s2_rd] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_s1_instr <= i_instr_word;
        end
        if (s1_adv) begin
            r_s2_npc    <= r_halted ? r_pc : ex.npc;
            r_s2_wr     <= eff && ex.wr;
            r_s2_rd     <= (eff && ex.wr) ? r_s1_instr[11:7] : 5'd0;
            r_s2_ld     <= eff && ex.ld;
            r_s2_val    <= eff ? ex.val : 32'd0;
            r_s2_st     <= eff && ex.st;
            r_s2_saddr  <= (eff && ex.st) ? maddr : '0;
            r_s2_sdata  <= (eff && ex.st) ? rs2_val : 32'd0;
            r_s2_status <= n_status;
        end
        r_w_rd  <= r_s2_rd;
        r_w_val <= s2_rd_value;
    end

    assign o_valid       = r_s2_v;
    assign o_next_pc     = r_s2_npc;
    assign o_rd_write    = r_s2_wr;
    assign o_rd_index    = r_s2_rd;
    assign o_rd_value    = s2_rd_value;
    assign o_store_valid = r_s2_st;
    assign o_store_addr  = 10'(r_s2_saddr);
    assign o_store_data  = r_s2_sdata;
    assign o_status      = r_s2_status;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("Halt flag dropped without reset.");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_stall)
        else $error("Instruction word taken during the memory clearing pass.");

    a_effects_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && (r_s2_wr || r_s2_st)) |->
        (r_s2_status == ST_OK || r_s2_status == ST_LOOP))
        else $error("Register write or store reported with an error or halted status.");

    a_fwd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_w_v |-> (r_w_rd != 5'd0))
        else $error("Register zero was written.");

endmodule

/* hdl/rvie_ram.sv */
module rvie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/rvie_exec.sv */
module rvie_exec import rvie_pkg::*; (
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_rs1_val,
    input  logic [31:0] i_rs2_val,
    output t_exec       o_res
);

    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] pc4;
    logic        take;
    t_exec       res;

    assign opc   = i_instr[6:0];
    assign f3    = i_instr[14:12];
    assign f7    = i_instr[31:25];
    assign rd    = i_instr[11:7];
    assign a     = i_rs1_val;
    assign b     = i_rs2_val;
    assign pc4   = i_pc + 32'd4;
    assign imm_i = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_b = {{20{i_instr[31]}}, i_instr[7], i_instr[30:25], i_instr[11:8], 1'b0};
    assign imm_j = {{12{i_instr[31]}}, i_instr[19:12], i_instr[20], i_instr[30:21], 1'b0};

    always_comb begin
        res  = '0;
        take = 1'b0;
        res.npc = pc4;
        case (opc)
            OPC_LOAD: begin
                res.wr = 1'b1;
                res.ld = 1'b1;
                res.ea = a + imm_i;
            end
            OPC_OPIMM: begin
                res.wr = 1'b1;
                case (f3)
                    F3_ADD:  res.val = a + imm_i;
                    F3_SLT:  res.val = {31'd0, $signed(a) < $signed(imm_i)};
                    F3_SLTU: res.val = {31'd0, a < imm_i};
                    F3_XOR:  res.val = a ^ imm_i;
                    F3_OR:   res.val = a | imm_i;
                    F3_AND:  res.val = a & imm_i;
                    default: res.err = 1'b1;
                endcase
            end
            OPC_STORE: begin
                res.st = 1'b1;
                res.ea = a + imm_s;
            end
            OPC_OP: begin
                res.wr = 1'b1;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_BASE) begin
                            res.val = a + b;
                        end else if (f7 == F7_ALT) begin
                            res.val = a - b;
                        end else begin
                            res.err = 1'b1;
                        end
                    end
                    F3_SLL:  res.val = a << b[4:0];
                    F3_SLT:  res.val = {31'd0, $signed(a) < $signed(b)};
                    F3_SLTU: res.val = {31'd0, a < b};
                    F3_XOR:  res.val = a ^ b;
                    F3_OR:   res.val = a | b;
                    F3_AND:  res.val = a & b;
                    default: res.err = 1'b1;
                endcase
            end
            OPC_LUI: begin
                res.wr  = 1'b1;
                res.val = {i_instr[31:12], 12'd0};
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: res.err = 1'b1;
                endcase
                if (take) begin
                    res.npc = i_pc + imm_b;
                end
            end
            OPC_JALR: begin
                res.wr  = 1'b1;
                res.val = pc4;
                res.npc = (a + imm_i) & 32'hffff_fffe;
            end
            OPC_JAL: begin
                res.wr  = 1'b1;
                res.val = pc4;
                res.npc = i_pc + imm_j;
            end
            default: res.err = 1'b1;
        endcase

        if (res.err) begin
            res.npc = i_pc;
            res.wr  = 1'b0;
            res.st  = 1'b0;
        end
        if (rd == 5'd0) begin
            res.wr = 1'b0;
        end
        res.ld = res.ld && res.wr;
        if (!res.wr) begin
            res.val = '0;
        end
    end

    assign o_res = res;

endmodule

/* verif/rv32i_integer_execute_tb.sv */
module rv32i_integer_execute_tb;
    import rvie_pkg::*;

    localparam int DATA_WORDS = 1024;

    localparam logic [2:0] F3_WORD        = 3'd2;
    localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;
    localparam logic [2:0] F3_BR_RSV2     = 3'd2;
    localparam logic [2:0] F3_BR_RSV3     = 3'd3;

    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
        logic        st;
        logic [9:0]  saddr;
        logic [31:0] sdata;
        t_status     status;
    } exec_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [31:0] i_instr_word = '0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_next_pc;
    logic        o_rd_write;
    logic [4:0]  o_rd_index;
    logic [31:0] o_rd_value;
    logic        o_store_valid;
    logic [9:0]  o_store_addr;
    logic [31:0] o_store_data;
    logic [1:0]  o_status;

    logic [31:0] arch_pc;
    logic [31:0] arch_regs [32];
    logic [31:0] data_mem [DATA_WORDS];
    bit          arch_halted;

    exec_result_t pending_results [$];
    int           mismatches = 0;
    int           results_seen = 0;
    bit           quiet_mode = 1'b0;
    int           stall_left = 0;

    rv32i_integer_execute #(.DATA_WORDS(DATA_WORDS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_instr_word  (i_instr_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_next_pc     (o_next_pc),
        .o_rd_write    (o_rd_write),
        .o_rd_index    (o_rd_index),
        .o_rd_value    (o_rd_value),
        .o_store_valid (o_store_valid),
        .o_store_addr  (o_store_addr),
        .o_store_data  (o_store_data),
        .o_status      (o_status)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
        return {imm, rd, OPC_LUI};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic exec_result_t predict_result(logic [31:0] w);
        exec_result_t r;
        logic [31:0]  a, b, val, npc, ea;
        logic [31:0]  imm_i, imm_s, imm_b, imm_j;
        logic [4:0]   rd;
        logic [2:0]   f3;
        logic [6:0]   f7;
        bit           wr, st, err, take;
        r = '0;
        r.npc = arch_pc;
        if (arch_halted) begin
            r.status = ST_HALTED;
            return r;
        end
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        rd = w[11:7];
        f3 = w[14:12];
        f7 = w[31:25];
        a = arch_regs[w[19:15]];
        b = arch_regs[w[24:20]];
        npc = arch_pc + 32'd4;
        val = '0;
        ea = '0;
        wr = 1'b0;
        st = 1'b0;
        err = 1'b0;
        take = 1'b0;
        case (w[6:0])
            OPC_LOAD: begin
                wr = 1'b1;
                ea = a + imm_i;
                val = data_mem[ea % DATA_WORDS];
            end
            OPC_OPIMM: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  val = a + imm_i;
                    F3_SLT:  val = {31'd0, $signed(a) < $signed(imm_i)};
                    F3_SLTU: val = {31'd0, a < imm_i};
                    F3_XOR:  val = a ^ imm_i;
                    F3_OR:   val = a | imm_i;
                    F3_AND:  val = a & imm_i;
                    default: err = 1'b1;
                endcase
            end
            OPC_STORE: begin
                st = 1'b1;
                ea = a + imm_s;
            end
            OPC_OP: begin
                wr = 1'b1;
                case (f3)
                    F3_ADD: begin
                        if (f7 == F7_BASE) val = a + b;
                        else if (f7 == F7_ALT) val = a - b;
                        else err = 1'b1;
                    end
                    F3_SLL:  val = a << b[4:0];
                    F3_SLT:  val = {31'd0, $signed(a) < $signed(b)};
                    F3_SLTU: val = {31'd0, a < b};
                    F3_XOR:  val = a ^ b;
                    F3_OR:   val = a | b;
                    F3_AND:  val = a & b;
                    default: err = 1'b1;
                endcase
            end
            OPC_LUI: begin
                wr = 1'b1;
                val = {w[31:12], 12'd0};
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: err = 1'b1;
                endcase
                if (take) npc = arch_pc + imm_b;
            end
            OPC_JALR: begin
                wr = 1'b1;
                val = arch_pc + 32'd4;
                npc = (a + imm_i) & 32'hffff_fffe;
            end
            OPC_JAL: begin
                wr = 1'b1;
                val = arch_pc + 32'd4;
                npc = arch_pc + imm_j;
            end
            default: err = 1'b1;
        endcase
        if (err) begin
            r.status = ST_ERR;
            return r;
        end
        if (rd == 5'd0) wr = 1'b0;
        r.npc = npc;
        r.wr = wr;
        r.idx = wr ? rd : 5'd0;
        r.val = wr ? val : 32'd0;
        r.st = st;
        r.saddr = st ? 10'(ea % DATA_WORDS) : 10'd0;
        r.sdata = st ? b : 32'd0;
        r.status = (npc == arch_pc) ? ST_LOOP : ST_OK;
        return r;
    endfunction

    function automatic int idle_cycles();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
    endfunction

    task automatic send_instr(input logic [31:0] w);
        int           gap;
        exec_result_t r;
        gap = (quiet_mode || $urandom_range(0, 1) == 1) ? 0 : idle_cycles();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_instr_word <= w;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        r = predict_result(w);
        if (r.status != ST_HALTED) begin
            if (r.status != ST_OK) arch_halted = 1'b1;
            if (r.wr) arch_regs[r.idx] = r.val;
            if (r.st) data_mem[r.saddr] = r.sdata;
            arch_pc = r.npc;
        end
        pending_results.push_back(r);
    endtask

    // Only instructions that neither fault nor jump to themselves are returned, so
    // the block stays live until the halt test at the very end.
    function automatic logic [31:0] random_instr();
        logic [31:0]  w;
        exec_result_t r;
        int           kind;
        logic [4:0]   rd, rs1, rs2;
        logic [2:0]   f3;
        logic [11:0]  imm;
        do begin
            rd = pick_reg();
            rs1 = pick_reg();
            rs2 = pick_reg();
            f3 = 3'($urandom);
            imm = 12'($urandom);
            kind = $urandom_range(0, 99);
            if (kind < 24 && $urandom_range(0, 1) == 1) begin
                rs1 = 5'd0;
                imm = 12'($urandom_range(0, 31));
            end
            if (kind < 12) w = enc_i(imm, rs1, f3, rd, OPC_LOAD);
            else if (kind < 24) w = enc_s(imm, rs2, rs1, f3);
            else if (kind < 44) w = enc_i(imm, rs1, f3, rd, OPC_OPIMM);
            else if (kind < 66) begin
                if (f3 == F3_ADD) w = enc_r($urandom_range(0, 1) ? F7_ALT : F7_BASE, rs2, rs1, f3, rd);
                else w = enc_r(7'($urandom), rs2, rs1, f3, rd);
            end
            else if (kind < 74) w = enc_u(20'($urandom), rd);
            else if (kind < 88) w = enc_b(13'($urandom) & 13'h1ffe, rs2, rs1, f3);
            else if (kind < 93) w = enc_j(21'($urandom) & 21'h1ffffe, rd);
            else if (kind < 97) w = enc_i(imm, rs1, f3, rd, OPC_JALR);
            else w = $urandom;
            r = predict_result(w);
        end while (r.status != ST_OK);
        return w;
    endfunction

    task automatic test_upper_and_immediate();
        send_instr(enc_u(20'hfffff, 5'd1));
        send_instr(enc_u(20'h80000, 5'd2));
        send_instr(enc_i(12'hfff, 5'd0, F3_ADD, 5'd3, OPC_OPIMM));
        send_instr(enc_i(12'h7ff, 5'd2, F3_SLT, 5'd5, OPC_OPIMM));
        send_instr(enc_i(12'hfff, 5'd3, F3_SLTU, 5'd6, OPC_OPIMM));
        // The result of this one is discarded since it targets x0.
        send_instr(enc_i(12'hfff, 5'd1, F3_XOR, 5'd0, OPC_OPIMM));
        send_instr(enc_i(12'h7ff, 5'd0, F3_OR, 5'd7, OPC_OPIMM));
        send_instr(enc_i(12'h800, 5'd1, F3_AND, 5'd8, OPC_OPIMM));
    endtask

    task automatic test_register_ops();
        send_instr(enc_r(F7_BASE, 5'd2, 5'd2, F3_ADD, 5'd9));
        send_instr(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd10));
        send_instr(enc_r(F7_BASE, 5'd3, 5'd3, F3_SLL, 5'd11));
        send_instr(enc_r(F7_BASE, 5'd7, 5'd2, F3_SLT, 5'd12));
        send_instr(enc_r(F7_BASE, 5'd7, 5'd2, F3_SLTU, 5'd13));
        send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd14));
        send_instr(enc_r(F7_BASE, 5'd2, 5'd7, F3_OR, 5'd15));
        send_instr(enc_r(F7_BASE, 5'd3, 5'd1, F3_AND, 5'd16));
    endtask

    task automatic test_memory();
        // A negative offset from x0 wraps to the last word of the memory.
        send_instr(enc_s(12'hfff, 5'd3, 5'd0, F3_WORD));
        send_instr(enc_i(12'hfff, 5'd0, F3_WORD, 5'd17, OPC_LOAD));
        send_instr(enc_i(12'h005, 5'd0, F3_WORD, 5'd19, OPC_LOAD));
    endtask

    task automatic test_branches_and_jumps();
        send_instr(enc_b(13'd8, 5'd0, 5'd9, F3_BEQ));
        send_instr(enc_b(13'h1ffc, 5'd1, 5'd1, F3_BNE));
        send_instr(enc_b(13'd12, 5'd0, 5'd2, F3_BLT));
        send_instr(enc_b(13'h1ff8, 5'd2, 5'd0, F3_BGE));
        send_instr(enc_b(13'd16, 5'd3, 5'd0, F3_BLTU));
        send_instr(enc_b(13'd4, 5'd3, 5'd7, F3_BGEU));
        send_instr(enc_j(21'h100000, 5'd1));
        send_instr(enc_i(12'h7ff, 5'd2, 3'($urandom), 5'd18, OPC_JALR));
    endtask

    task automatic test_random_mix();
        repeat (1000) send_instr(random_instr());
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        repeat (280) send_instr(random_instr());
        quiet_mode = 1'b0;
    endtask

    task automatic test_halt();
        logic [31:0]  w;
        logic [6:0]   f7;
        logic [4:0]   rs;
        exec_result_t r;
        case ($urandom_range(0, 6))
            0: begin
                do begin
                    w = $urandom;
                    r = predict_result(w);
                end while (r.status != ST_ERR);
            end
            1: w = enc_i(12'($urandom), pick_reg(), $urandom_range(0, 1) ? F3_SLL : F3_SHIFT_RIGHT,
                         pick_reg(), OPC_OPIMM);
            2: w = enc_r(7'($urandom), pick_reg(), pick_reg(), F3_SHIFT_RIGHT, pick_reg());
            3: begin
                do begin
                    f7 = 7'($urandom);
                end while (f7 == F7_BASE || f7 == F7_ALT);
                w = enc_r(f7, pick_reg(), pick_reg(), F3_ADD, pick_reg());
            end
            4: w = enc_b(13'($urandom) & 13'h1ffe, pick_reg(), pick_reg(),
                         $urandom_range(0, 1) ? F3_BR_RSV2 : F3_BR_RSV3);
            5: w = enc_j(21'd0, pick_reg());
            default: begin
                rs = pick_reg();
                w = enc_b(13'd0, rs, rs, F3_BEQ);
            end
        endcase
        send_instr(w);
        repeat (8) send_instr($urandom);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 30)
            $display("mismatch in %s of word %0d: got %h, want %h", what, results_seen, got, want);
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            stall_left = idle_cycles();
        end else begin
            i_stall <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        exec_result_t want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, next_pc", o_next_pc, 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_next_pc !== want.npc) report_mismatch("next_pc", o_next_pc, want.npc);
                if (o_rd_write !== want.wr) report_mismatch("rd_write", 32'(o_rd_write), 32'(want.wr));
                if (o_rd_index !== want.idx) report_mismatch("rd_index", 32'(o_rd_index), 32'(want.idx));
                if (o_rd_value !== want.val) report_mismatch("rd_value", o_rd_value, want.val);
                if (o_store_valid !== want.st)
                    report_mismatch("store_valid", 32'(o_store_valid), 32'(want.st));
                if (o_store_addr !== want.saddr)
                    report_mismatch("store_addr", 32'(o_store_addr), 32'(want.saddr));
                if (o_store_data !== want.sdata) report_mismatch("store_data", o_store_data, want.sdata);
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
            end
            results_seen++;
        end
    end

    initial begin
        arch_pc = '0;
        arch_halted = 1'b0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (data_mem[i]) data_mem[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_upper_and_immediate();
        test_register_ops();
        test_memory();
        test_branches_and_jumps();
        test_random_mix();
        test_back_to_back();
        test_halt();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rvie_pkg.sv
hdl/rvie_ram.sv
hdl/rvie_exec.sv
hdl/rv32i_integer_execute.sv
verif/rv32i_integer_execute_tb.sv
